// ===== src/kegr_pkg.sv =====
// kegr_pkg: types, codes and constants shared by the key event mapper
// and its angle unit
// no dependencies
package kegr_pkg;

    localparam int D_MAP_ENTRIES  = 64;
    localparam int D_NUM_AXES     = 18;
    localparam int D_NUM_HATS     = 4;
    localparam int D_BUTTON_WORDS = 4;
    localparam int C_MAX_RESULTS  = 26;

    localparam logic [31:0] C_CENTRE   = 32'h8000_0000;
    localparam logic [31:0] C_NO_ANGLE = 32'hFFFF_FFFF;

    // item kinds
    localparam logic [1:0] K_SELECT = 2'd0;
    localparam logic [1:0] K_EVENT  = 2'd1;
    localparam logic [1:0] K_FLUSH  = 2'd2;
    localparam logic [1:0] K_LOAD   = 2'd3;

    // mapping targets
    localparam logic [1:0] M_BUTTON = 2'd0;
    localparam logic [1:0] M_HAT    = 2'd1;
    localparam logic [1:0] M_AXIS   = 2'd2;
    localparam logic [1:0] M_BAD    = 2'd3;

    // result status codes
    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_NO_MAP   = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_STORED   = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_SELECTED = 3'd5;
    localparam logic [2:0] ST_FLUSH    = 3'd6;

    // report field kinds
    localparam logic [1:0] FK_NONE   = 2'd0;
    localparam logic [1:0] FK_BUTTON = 2'd1;
    localparam logic [1:0] FK_AXIS   = 2'd2;
    localparam logic [1:0] FK_HAT    = 2'd3;

    // angle unit: hundredths of a degree scaled by 2^16
    localparam int                 C_CORDIC_STEPS = 29;
    localparam int                 C_PRE_SHIFT    = 28;
    localparam logic signed [33:0] C_ANG_HALF     = 34'sd1179648000;
    localparam logic signed [33:0] C_ANG_FULL     = 34'sd2359296000;
    localparam logic signed [33:0] C_ANG_ROUND    = 34'sd32768;
    localparam logic [15:0]        C_ANG_WRAP     = 16'd36000;

    localparam logic [28:0] C_ATAN [C_CORDIC_STEPS] = '{
        29'd294912000, 29'd174096719, 29'd91987925, 29'd46694507, 29'd23437865,
        29'd11730358, 29'd5866610, 29'd2933484, 29'd1466764, 29'd733385,
        29'd366693, 29'd183346, 29'd91673, 29'd45837, 29'd22918, 29'd11459,
        29'd5730, 29'd2865, 29'd1432, 29'd716, 29'd358, 29'd179, 29'd90,
        29'd45, 29'd22, 29'd11, 29'd6, 29'd3, 29'd1
    };

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] src_device;
        logic [31:0] key_id;
        logic [31:0] value;
        logic [1:0]  map_type;
        logic [7:0]  map_index;
        logic        map_horizontal;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  field_kind;
        logic [4:0]  field_index;
        logic [31:0] field_value;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [63:0] match;
        logic [10:0] target;
    } t_entry;

endpackage

// ===== src/key_event_to_gamepad_report.sv =====
// key_event_to_gamepad_report: maps (device, key, value) events through a
// loaded table onto gamepad report fields; top level
// depends on kegr_pkg and kegr_cordic
//
//   channel  | direction | signals
//   ---------+-----------+----------------------------------------
//   input    | in        | i_in_valid, i_in (t_in_item), o_in_stall
//   output   | out       | o_out_valid, o_out (t_out_item), i_out_stall
//
// one item at a time; a load or key event scans the table at one entry per cycle
// through the memory read port, and a hat update also waits on the shared cordic
// stage; a flush sends one transfer per cycle while the output is not stalled.
// reset clears the table valid bits and report state at once, no sweep.
// a stalled output holds its transfer; the next item may enter meanwhile.
module key_event_to_gamepad_report import kegr_pkg::*; #(
    parameter int MAP_ENTRIES  = D_MAP_ENTRIES,
    parameter int NUM_AXES     = D_NUM_AXES,
    parameter int NUM_HATS     = D_NUM_HATS,
    parameter int BUTTON_WORDS = D_BUTTON_WORDS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out,
    input  logic      i_out_stall
);

    localparam int AW    = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int BWW   = (BUTTON_WORDS > 1) ? $clog2(BUTTON_WORDS) : 1;
    localparam int AXW   = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int HW    = (NUM_HATS > 1) ? $clog2(NUM_HATS) : 1;
    localparam int TOTAL = (BUTTON_WORDS + NUM_AXES + NUM_HATS > C_MAX_RESULTS) ?
                           C_MAX_RESULTS : BUTTON_WORDS + NUM_AXES + NUM_HATS;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SCAN     = 9'b000000010,
        S_RESOLVE  = 9'b000000100,
        S_BTN      = 9'b000001000,
        S_AXIS     = 9'b000010000,
        S_HAT_LD   = 9'b000100000,
        S_HAT_WAIT = 9'b001000000,
        S_EMIT     = 9'b010000000,
        S_FLUSH    = 9'b100000000
    } t_state;

    t_state       r_state;
    logic         r_out_vld;
    t_out_item    r_out;

    // item payload
    logic [1:0]   r_kind;
    logic [31:0]  r_value;
    logic [1:0]   r_mtype;
    logic [7:0]   r_midx;
    logic         r_mhor;
    logic [63:0]  r_match;
    logic [2:0]   r_res_status;
    logic [1:0]   r_res_kind;
    logic [31:0]  r_res_value;

    // table
    t_entry       r_mem [MAP_ENTRIES];
    logic         r_valid [MAP_ENTRIES];
    logic [AW:0]  r_scan;
    t_entry       r_rd_ent;
    logic         r_rd_vld;
    logic [AW-1:0] r_rd_idx;
    logic         r_rd_live;
    logic         r_hit;
    logic [AW-1:0] r_slot;
    logic [10:0]  r_tgt;
    logic         r_free_vld;
    logic [AW-1:0] r_free_idx;

    // report state
    logic [31:0]  r_sel_dev;
    logic [31:0]  r_btn [BUTTON_WORDS];
    logic [15:0]  r_axis [NUM_AXES];
    logic [31:0]  r_hat_val [NUM_HATS];
    logic [31:0]  r_hat_h [NUM_HATS];
    logic [31:0]  r_hat_v [NUM_HATS];

    logic [4:0]   r_fidx;
    logic [4:0]   r_bit;
    logic [1:0]   r_seg;
    logic [4:0]   r_n;

    logic         accept, out_free, hit_now, end_now, scan_more;
    logic         mem_we;
    logic [AW-1:0] wr_slot;
    logic [AW-1:0] scan_addr;
    logic [1:0]   ty;
    logic [7:0]   id;
    logic [31:0]  btn_word, btn_new, btn_mask;
    logic [48:0]  num;
    logic [15:0]  q_est, q_axis;
    logic [33:0]  rem;
    logic [31:0]  flush_val;
    logic         flush_last, seg_end;
    logic         c_start, c_done;
    logic [31:0]  c_angle;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_vld || !i_out_stall;
    assign scan_addr  = r_scan[AW-1:0];
    assign scan_more  = (r_scan < (AW+1)'(MAP_ENTRIES));
    assign hit_now    = r_rd_live && r_rd_vld && (r_rd_ent.match == r_match);
    assign end_now    = r_rd_live && (r_rd_idx == AW'(MAP_ENTRIES - 1));
    assign ty         = r_tgt[10:9];
    assign id         = r_tgt[8:1];
    assign wr_slot    = r_hit ? r_slot : r_free_idx;
    assign mem_we     = (r_state == S_RESOLVE) && (r_kind == K_LOAD) &&
                        (r_hit || r_free_vld);
    assign c_start    = (r_state == S_HAT_LD);

    always_comb begin
        btn_word = r_btn[r_fidx[BWW-1:0]];
        btn_mask = 32'd1 << r_bit;
        btn_new  = (r_value > C_CENTRE) ? (btn_word | btn_mask) : (btn_word & ~btn_mask);
        // round(value * 2^16 / (2 * (2^32 - 1))): estimate by >> 33, fix by at most one
        num    = {1'b0, r_value, 16'd0} + {17'd0, 32'hFFFF_FFFF};
        q_est  = num[48:33];
        rem    = {1'b0, num[32:0]} + {17'd0, q_est, 1'b0};
        q_axis = (rem >= 34'h1_FFFF_FFFE) ? (q_est + 16'd1) : q_est;
        case (r_seg)
            FK_BUTTON: begin
                flush_val = r_btn[r_fidx[BWW-1:0]];
                seg_end   = (r_fidx == 5'(BUTTON_WORDS - 1));
            end
            FK_AXIS: begin
                flush_val = {16'd0, r_axis[r_fidx[AXW-1:0]]};
                seg_end   = (r_fidx == 5'(NUM_AXES - 1));
            end
            default: begin
                flush_val = r_hat_val[r_fidx[HW-1:0]];
                seg_end   = (r_fidx == 5'(NUM_HATS - 1));
            end
        endcase
        flush_last = (r_n == 5'(TOTAL - 1));
    end

    // table memory, one read per cycle during the scan
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_slot] <= '{match: r_match, target: {r_mtype, r_midx, r_mhor}};
        end
        r_rd_ent <= r_mem[scan_addr];
    end

    kegr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_start),
        .i_h     (r_hat_h[r_fidx[HW-1:0]]),
        .i_v     (r_hat_v[r_fidx[HW-1:0]]),
        .o_done  (c_done),
        .o_angle (c_angle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_vld  <= 1'b0;
            r_rd_live  <= 1'b0;
            r_free_vld <= 1'b0;
            r_hit      <= 1'b0;
            r_sel_dev  <= '0;
            for (int i = 0; i < MAP_ENTRIES; i++) r_valid[i] <= 1'b0;
            for (int i = 0; i < BUTTON_WORDS; i++) r_btn[i] <= '0;
            for (int i = 0; i < NUM_AXES; i++) r_axis[i] <= '0;
            for (int i = 0; i < NUM_HATS; i++) begin
                r_hat_val[i] <= '0;
                r_hat_h[i]   <= C_CENTRE;
                r_hat_v[i]   <= C_CENTRE;
            end
        end else begin
            if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            r_rd_vld  <= r_valid[scan_addr];
            r_rd_idx  <= scan_addr;
            r_rd_live <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind     <= i_in.kind;
                        r_value    <= i_in.value;
                        r_mtype    <= i_in.map_type;
                        r_midx     <= i_in.map_index;
                        r_mhor     <= i_in.map_horizontal;
                        r_scan     <= '0;
                        r_free_vld <= 1'b0;
                        r_hit      <= 1'b0;
                        r_fidx     <= '0;
                        r_seg      <= FK_BUTTON;
                        r_n        <= '0;
                        r_res_kind  <= FK_NONE;
                        r_res_value <= '0;
                        unique case (i_in.kind)
                            K_SELECT: begin
                                r_sel_dev    <= i_in.src_device;
                                r_res_status <= ST_SELECTED;
                                r_state      <= S_EMIT;
                            end
                            K_FLUSH: r_state <= S_FLUSH;
                            K_LOAD: begin
                                r_match <= {i_in.src_device, i_in.key_id};
                                if (i_in.map_type == M_BAD) begin
                                    r_res_status <= ST_RANGE;
                                    r_state      <= S_EMIT;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                                r_match <= {r_sel_dev, i_in.key_id};
                                r_state <= S_SCAN;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (scan_more) begin
                        r_scan <= r_scan + (AW+1)'(1);
                    end
                    if (r_rd_live && !r_rd_vld && !r_free_vld) begin
                        r_free_vld <= 1'b1;
                        r_free_idx <= r_rd_idx;
                    end
                    if (hit_now) begin
                        r_hit   <= 1'b1;
                        r_slot  <= r_rd_idx;
                        r_tgt   <= r_rd_ent.target;
                        r_state <= S_RESOLVE;
                    end else if (end_now) begin
                        r_state <= S_RESOLVE;
                    end else begin
                        r_rd_live <= scan_more;
                    end
                end
                S_RESOLVE: begin
                    r_state <= S_EMIT;
                    if (r_kind == K_LOAD) begin
                        if (r_hit || r_free_vld) begin
                            r_valid[wr_slot] <= 1'b1;
                            r_res_status     <= ST_STORED;
                        end else begin
                            r_res_status <= ST_FULL;
                        end
                    end else if (!r_hit) begin
                        r_res_status <= ST_NO_MAP;
                    end else begin
                        r_res_status <= ST_RANGE;
                        if (ty == M_BUTTON) begin
                            if ({5'd0, id[7:5]} < 8'(BUTTON_WORDS)) begin
                                r_fidx  <= {2'd0, id[7:5]};
                                r_bit   <= id[4:0];
                                r_state <= S_BTN;
                            end
                        end else if (ty == M_AXIS) begin
                            if (id < 8'(NUM_AXES)) begin
                                r_fidx  <= id[4:0];
                                r_state <= S_AXIS;
                            end
                        end else if (ty == M_HAT) begin
                            if (id < 8'(NUM_HATS)) begin
                                r_fidx <= id[4:0];
                                if (r_tgt[0]) begin
                                    r_hat_h[id[HW-1:0]] <= r_value;
                                end else begin
                                    r_hat_v[id[HW-1:0]] <= r_value;
                                end
                                r_state <= S_HAT_LD;
                            end
                        end
                    end
                end
                S_BTN: begin
                    r_btn[r_fidx[BWW-1:0]] <= btn_new;
                    r_res_status <= ST_UPDATED;
                    r_res_kind   <= FK_BUTTON;
                    r_res_value  <= btn_new;
                    r_state      <= S_EMIT;
                end
                S_AXIS: begin
                    r_axis[r_fidx[AXW-1:0]] <= q_axis;
                    r_res_status <= ST_UPDATED;
                    r_res_kind   <= FK_AXIS;
                    r_res_value  <= {16'd0, q_axis};
                    r_state      <= S_EMIT;
                end
                S_HAT_LD: r_state <= S_HAT_WAIT;
                S_HAT_WAIT: begin
                    if (c_done) begin
                        r_hat_val[r_fidx[HW-1:0]] <= c_angle;
                        r_res_status <= ST_UPDATED;
                        r_res_kind   <= FK_HAT;
                        r_res_value  <= c_angle;
                        r_state      <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_out     <= '{status: r_res_status, field_kind: r_res_kind,
                                       field_index: r_fidx, field_value: r_res_value,
                                       last: 1'b1};
                        r_state   <= S_IDLE;
                    end
                end
                S_FLUSH: begin
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_out     <= '{status: ST_FLUSH, field_kind: r_seg,
                                       field_index: r_fidx, field_value: flush_val,
                                       last: flush_last};
                        r_n <= r_n + 5'd1;
                        if (seg_end) begin
                            r_fidx <= '0;
                            r_seg  <= r_seg + 2'd1;
                        end else begin
                            r_fidx <= r_fidx + 5'd1;
                        end
                        if (flush_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

// ===== src/kegr_cordic.sv =====
// kegr_cordic: iterative vectoring cordic giving the hat angle from its
// two raw components, one rotation per cycle
// depends on kegr_pkg
module kegr_cordic import kegr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_h,
    input  logic [31:0] i_v,
    output logic        o_done,
    output logic [31:0] o_angle
);

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_RUN  = 4'b0010,
        C_FIX  = 4'b0100,
        C_FIN  = 4'b1000
    } t_cstate;

    t_cstate            r_state;
    logic               r_done;
    logic [31:0]        r_angle;
    logic signed [63:0] r_x, r_y;
    logic signed [33:0] r_z;
    logic [4:0]         r_it;

    logic signed [32:0] hc, vc;
    logic signed [63:0] xs, ys, dx, dy;
    logic signed [33:0] zs, zr;
    logic signed [33:0] atan_s;
    logic [15:0]        q;

    // shift toward zero, as the angle table assumes
    function automatic logic signed [63:0] asr(input logic signed [63:0] v,
                                               input logic [4:0] s);
        logic signed [63:0] m;
        m = -v;
        return v[63] ? -(m >>> s) : (v >>> s);
    endfunction

    always_comb begin
        hc     = $signed({1'b0, i_h}) - $signed({1'b0, C_CENTRE});
        vc     = $signed({1'b0, i_v}) - $signed({1'b0, C_CENTRE});
        xs     = $signed({{31{vc[32]}}, vc}) <<< C_PRE_SHIFT;
        ys     = $signed({{31{hc[32]}}, hc}) <<< C_PRE_SHIFT;
        dx     = asr(r_y, r_it);
        dy     = asr(r_x, r_it);
        atan_s = $signed({5'd0, C_ATAN[r_it]});
        zs     = r_z;
        if (r_z < 0) begin
            zs = r_z + C_ANG_FULL;
        end else if (r_z >= C_ANG_FULL) begin
            zs = r_z - C_ANG_FULL;
        end
        zr = r_z + C_ANG_ROUND;
        q  = zr[31:16];
        if (q >= C_ANG_WRAP) begin
            q = q - C_ANG_WRAP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        if (hc == 0 && vc == 0) begin
                            r_angle <= C_NO_ANGLE;
                            r_done  <= 1'b1;
                        end else begin
                            if (vc < 0) begin
                                r_x <= -xs;
                                r_y <= -ys;
                                r_z <= C_ANG_HALF;
                            end else begin
                                r_x <= xs;
                                r_y <= ys;
                                r_z <= '0;
                            end
                            r_it    <= '0;
                            r_state <= C_RUN;
                        end
                    end
                end
                C_RUN: begin
                    if (r_y > 0) begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + atan_s;
                    end else begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - atan_s;
                    end
                    r_it <= r_it + 5'd1;
                    if (r_it == 5'(C_CORDIC_STEPS - 1)) begin
                        r_state <= C_FIX;
                    end
                end
                C_FIX: begin
                    r_z     <= zs;
                    r_state <= C_FIN;
                end
                C_FIN: begin
                    r_angle <= {16'd0, q};
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_angle;

endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for key_event_to_gamepad_report
// holds its own predictor of the mapping table, report fields and hat angle
// depends on kegr_pkg and the block itself
`timescale 1ns / 1ps

module testbench;
    import kegr_pkg::*;

    localparam int LIMIT = 600000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_item  i_in;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out;
    logic      i_out_stall;

    key_event_to_gamepad_report dut (.*);

    // predictor state
    bit          map_used [D_MAP_ENTRIES];
    logic [63:0] map_pair [D_MAP_ENTRIES];
    logic [10:0] map_dest [D_MAP_ENTRIES];
    logic [31:0] cur_device;
    logic [31:0] buttons [D_BUTTON_WORDS];
    logic [31:0] axes [D_NUM_AXES];
    logic [31:0] hats [D_NUM_HATS];
    logic [31:0] hat_raw [2*D_NUM_HATS];

    t_out_item report_q[$];
    int        errors = 0;
    int        cycles = 0;
    int        n_items = 0;
    int        n_results = 0;
    bit        quiet = 0;
    int        hold_req = 0;
    logic [31:0] devs [4];

    typedef struct {
        t_in_item   it;
        bit         typed;
        logic [2:0] st;
    } t_row;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint shr_sym(longint v, int s);
        return v >= 0 ? (v >>> s) : -((-v) >>> s);
    endfunction

    function automatic logic [31:0] hat_heading(logic [31:0] h, logic [31:0] v);
        longint y, x, z, dx, dy, full;
        logic [63:0] q;
        y = longint'({32'd0, h}) - longint'({32'd0, C_CENTRE});
        x = longint'({32'd0, v}) - longint'({32'd0, C_CENTRE});
        z = 0;
        full = longint'(C_ANG_FULL);
        if (x == 0 && y == 0) return C_NO_ANGLE;
        x = x <<< 28;
        y = y <<< 28;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = longint'(C_ANG_HALF);
        end
        for (int i = 0; i < C_CORDIC_STEPS; i++) begin
            dx = shr_sym(y, i);
            dy = shr_sym(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += longint'({35'd0, C_ATAN[i]});
            end else begin
                x -= dx; y += dy; z -= longint'({35'd0, C_ATAN[i]});
            end
        end
        if (z < 0) z += full;
        if (z >= full) z -= full;
        q = (z + 32768) >> 16;
        return 32'(q % 36000);
    endfunction

    function automatic t_out_item res(logic [2:0] st, logic [1:0] fk, int idx,
                                      logic [31:0] val, bit lst);
        t_out_item r;
        r.status = st;
        r.field_kind = fk;
        r.field_index = 5'(idx);
        r.field_value = val;
        r.last = lst;
        return r;
    endfunction

    function automatic int find_pair(logic [63:0] m);
        for (int i = 0; i < D_MAP_ENTRIES; i++)
            if (map_used[i] && map_pair[i] == m) return i;
        return -1;
    endfunction

    // works out the results of one accepted item and queues them
    function automatic void predict_report(t_in_item it);
        int slot, n, total, id;
        logic [10:0] t;
        logic [63:0] num;
        total = D_BUTTON_WORDS + D_NUM_AXES + D_NUM_HATS;
        if (total > C_MAX_RESULTS) total = C_MAX_RESULTS;
        case (it.kind)
            K_SELECT: begin
                cur_device = it.src_device;
                report_q.push_back(res(ST_SELECTED, FK_NONE, 0, 0, 1));
            end
            K_FLUSH: begin
                n = 0;
                for (int i = 0; i < D_BUTTON_WORDS && n < total; i++, n++)
                    report_q.push_back(res(ST_FLUSH, FK_BUTTON, i, buttons[i], n == total-1));
                for (int i = 0; i < D_NUM_AXES && n < total; i++, n++)
                    report_q.push_back(res(ST_FLUSH, FK_AXIS, i, axes[i], n == total-1));
                for (int i = 0; i < D_NUM_HATS && n < total; i++, n++)
                    report_q.push_back(res(ST_FLUSH, FK_HAT, i, hats[i], n == total-1));
            end
            K_LOAD: begin
                if (it.map_type == M_BAD) begin
                    report_q.push_back(res(ST_RANGE, FK_NONE, 0, 0, 1));
                    return;
                end
                slot = find_pair({it.src_device, it.key_id});
                if (slot < 0)
                    for (int i = 0; i < D_MAP_ENTRIES; i++)
                        if (!map_used[i]) begin
                            slot = i;
                            break;
                        end
                if (slot < 0) begin
                    report_q.push_back(res(ST_FULL, FK_NONE, 0, 0, 1));
                    return;
                end
                map_used[slot] = 1;
                map_pair[slot] = {it.src_device, it.key_id};
                map_dest[slot] = {it.map_type, it.map_index, it.map_horizontal};
                report_q.push_back(res(ST_STORED, FK_NONE, 0, 0, 1));
            end
            default: begin
                slot = find_pair({cur_device, it.key_id});
                if (slot < 0) begin
                    report_q.push_back(res(ST_NO_MAP, FK_NONE, 0, 0, 1));
                    return;
                end
                t = map_dest[slot];
                id = int'(t[8:1]);
                if (t[10:9] == M_BUTTON && (id >> 5) < D_BUTTON_WORDS) begin
                    if (it.value > C_CENTRE) buttons[id >> 5][id & 31] = 1'b1;
                    else buttons[id >> 5][id & 31] = 1'b0;
                    report_q.push_back(res(ST_UPDATED, FK_BUTTON, id >> 5,
                                           buttons[id >> 5], 1));
                end else if (t[10:9] == M_AXIS && id < D_NUM_AXES) begin
                    num = ({32'd0, it.value} << 16) + 64'hFFFF_FFFF;
                    axes[id] = {16'd0, 16'(num / 64'h1_FFFF_FFFE)};
                    report_q.push_back(res(ST_UPDATED, FK_AXIS, id, axes[id], 1));
                end else if (t[10:9] == M_HAT && id < D_NUM_HATS) begin
                    hat_raw[id*2 + (t[0] ? 0 : 1)] = it.value;
                    hats[id] = hat_heading(hat_raw[id*2], hat_raw[id*2+1]);
                    report_q.push_back(res(ST_UPDATED, FK_HAT, id, hats[id], 1));
                end else begin
                    report_q.push_back(res(ST_RANGE, FK_NONE, 0, 0, 1));
                end
            end
        endcase
    endfunction

    function automatic bit value_ok(t_out_item e, t_out_item a);
        int d;
        if (e.field_value == a.field_value) return 1;
        // hat angles may be off by one, with wrap at a full turn
        if (e.field_kind != FK_HAT || e.field_value == C_NO_ANGLE
            || a.field_value == C_NO_ANGLE) return 0;
        d = int'(e.field_value) - int'(a.field_value);
        return d == 1 || d == -1 || d == 35999 || d == -35999;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (report_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer %h", $realtime, o_out);
            end else begin
                e = report_q.pop_front();
                if (e.status != o_out.status || e.field_kind != o_out.field_kind
                    || e.field_index != o_out.field_index || e.last != o_out.last
                    || !value_ok(e, o_out)) begin
                    errors++;
                    $display("%0t: mismatch expected st=%0d fk=%0d idx=%0d val=%h last=%0d",
                             $realtime, e.status, e.field_kind, e.field_index,
                             e.field_value, e.last);
                    $display("%0t:          actual st=%0d fk=%0d idx=%0d val=%h last=%0d",
                             $realtime, o_out.status, o_out.field_kind,
                             o_out.field_index, o_out.field_value, o_out.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver stall, with one long hold-off on request
    initial begin
        i_out_stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                i_out_stall = 1;
                hold_req--;
            end else begin
                i_out_stall = !quiet && ($urandom_range(99) < 15);
            end
        end
    end

    task automatic send_item(t_in_item it, bit typed, logic [2:0] st);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(99) < 15) gap = $urandom_range(1, 6);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 0;
            repeat (gap) @(negedge i_clk);
        end
        i_in = it;
        i_in_valid = 1;
        do @(posedge i_clk); while (o_in_stall);
        predict_report(it);
        if (typed) report_q[$] = res(st, FK_NONE, 0, 0, 1);
        n_items++;
    endtask

    function automatic t_in_item mk(logic [1:0] k, logic [31:0] dv, logic [31:0] ky,
                                    logic [31:0] v, logic [1:0] mt, logic [7:0] mi,
                                    logic mh);
        t_in_item it;
        it.kind = k; it.src_device = dv; it.key_id = ky; it.value = v;
        it.map_type = mt; it.map_index = mi; it.map_horizontal = mh;
        return it;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return C_CENTRE;
            2: return C_CENTRE + 1;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        t_row rows[$];
        t_in_item it;
        int r, d;
        for (int i = 0; i < D_MAP_ENTRIES; i++) map_used[i] = 0;
        cur_device = 0;
        foreach (buttons[i]) buttons[i] = 0;
        foreach (axes[i]) axes[i] = 0;
        foreach (hats[i]) hats[i] = 0;
        foreach (hat_raw[i]) hat_raw[i] = C_CENTRE;
        i_in_valid = 0;
        i_in = '0;
        i_rst_n = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        rows = '{
            '{mk(K_FLUSH, 0, 0, 0, M_BUTTON, 0, 0), 0, ST_FLUSH},
            '{mk(K_SELECT, '1, 0, 0, M_BUTTON, 0, 0), 1, ST_SELECTED},
            '{mk(K_LOAD, '1, '1, 0, M_BUTTON, 8'd127, 1), 1, ST_STORED},
            '{mk(K_EVENT, 0, '1, '1, M_BUTTON, 0, 0), 0, ST_UPDATED},
            '{mk(K_LOAD, '1, '1, 0, M_BAD, '1, 1), 1, ST_RANGE},
            '{mk(K_EVENT, 0, 0, '1, M_BUTTON, 0, 0), 1, ST_NO_MAP},
            '{mk(K_SELECT, 0, '1, '1, M_BAD, '1, 1), 1, ST_SELECTED},
            '{mk(K_LOAD, 0, 1, 0, M_AXIS, 8'd17, 0), 1, ST_STORED},
            '{mk(K_LOAD, 0, 2, 0, M_AXIS, 8'd18, 0), 1, ST_STORED},
            '{mk(K_LOAD, 0, 3, 0, M_HAT, 8'd0, 1), 1, ST_STORED},
            '{mk(K_LOAD, 0, 4, 0, M_HAT, 8'd0, 0), 1, ST_STORED},
            '{mk(K_LOAD, 0, 5, 0, M_HAT, 8'd4, 1), 1, ST_STORED},
            '{mk(K_LOAD, 0, 6, 0, M_BUTTON, 8'd128, 0), 1, ST_STORED},
            '{mk(K_EVENT, 0, 1, '1, M_BUTTON, 0, 0), 0, ST_UPDATED},
            '{mk(K_EVENT, 0, 1, 0, M_BUTTON, 0, 0), 0, ST_UPDATED},
            '{mk(K_EVENT, 0, 2, 0, M_BUTTON, 0, 0), 1, ST_RANGE},
            '{mk(K_EVENT, 0, 5, 0, M_BUTTON, 0, 0), 1, ST_RANGE},
            '{mk(K_EVENT, 0, 6, '1, M_BUTTON, 0, 0), 1, ST_RANGE},
            '{mk(K_EVENT, 0, 3, C_CENTRE, M_BUTTON, 0, 0), 0, ST_UPDATED},
            '{mk(K_EVENT, 0, 3, '1, M_BUTTON, 0, 0), 0, ST_UPDATED},
            '{mk(K_EVENT, 0, 4, 0, M_BUTTON, 0, 0), 0, ST_UPDATED},
            '{mk(K_LOAD, 0, 3, 0, M_BUTTON, 8'd0, 0), 1, ST_STORED},
            '{mk(K_EVENT, 0, 3, C_CENTRE + 1, M_BUTTON, 0, 0), 0, ST_UPDATED},
            '{mk(K_EVENT, 0, 3, C_CENTRE, M_BUTTON, 0, 0), 0, ST_UPDATED},
            '{mk(K_FLUSH, '1, '1, '1, M_BAD, '1, 1), 0, ST_FLUSH}
        };
        foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].st);

        foreach (devs[i]) devs[i] = $urandom;
        devs[0] = 0;
        for (int n = 0; n < 300; n++) begin
            quiet = (n >= 100 && n < 140);
            if (n == 180) hold_req = 400;
            d = $urandom_range(3);
            r = $urandom_range(99);
            it = mk(K_EVENT, $urandom, {27'd0, 5'($urandom)}, pick_value(),
                    2'($urandom_range(2)), 8'($urandom_range(40)), 1'($urandom));
            if (r < 8) begin
                it.kind = K_SELECT;
                it.src_device = ($urandom_range(9) == 0) ? $urandom : devs[d];
            end else if (r < 13) begin
                it.kind = K_FLUSH;
            end else if (r < 43) begin
                it.kind = K_LOAD;
                it.src_device = devs[d];
                if ($urandom_range(9) == 0) it.map_index = $urandom;
                if ($urandom_range(19) == 0) it.map_type = M_BAD;
                if ($urandom_range(9) == 0) it.key_id = $urandom;
            end else if ($urandom_range(9) == 0) begin
                it.key_id = $urandom;
            end
            send_item(it, 0, ST_UPDATED);
        end

        @(negedge i_clk);
        i_in_valid = 0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("%0d items sent, %0d transfers checked: loads, events on all targets,",
                 n_items, n_results);
        $display("flushes, table full, long output hold-off and random idling");
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/kegr_pkg.sv
src/kegr_cordic.sv
src/key_event_to_gamepad_report.sv
dv/testbench.sv
